// ===== design/ght_pkg.sv =====
`default_nettype none

package ght_pkg;

    localparam int SLOTS       = 1024;
    localparam int INDEX_BITS  = 20;
    localparam int HANDLE_BITS = 32;
    localparam int GEN_BITS    = HANDLE_BITS - INDEX_BITS;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS    = $clog2(SLOTS + 1);
    localparam int PAYLOAD_BITS = 64;
    localparam int STAGE_BITS  = 2;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_BITS-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DESTROY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_ZERO = 2'd3;

    localparam logic [STAGE_BITS-1:0] STAGE_VERTEX = 2'd0;
    localparam logic [STAGE_BITS-1:0] STAGE_BAD    = 2'd3;

    typedef struct packed {
        logic [CMD_BITS-1:0]     command;
        logic [HANDLE_BITS-1:0]  handle_in;
        logic [PAYLOAD_BITS-1:0] payload_in;
        logic [STAGE_BITS-1:0]   stage_in;
    } ght_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [HANDLE_BITS-1:0]  handle_out;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [STAGE_BITS-1:0]   stage_out;
    } ght_rsp_t;

    typedef enum logic [1:0] {
        OP_CREATE,
        OP_DESTROY,
        OP_LOOKUP,
        OP_REJECT
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [STATUS_BITS-1:0]  status;
        logic [SLOT_BITS-1:0]    idx;
        logic [GEN_BITS-1:0]     gen;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [STAGE_BITS-1:0]   stage;
    } ght_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STACK,
        BK_READ
    } bk_state_t;

endpackage

`default_nettype wire

// ===== design/ght_front.sv =====
`default_nettype none

module ght_front
    import ght_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ght_req_t req,
    output logic          busy,
    input  wire logic     slot_taken,
    output logic          push,
    output ght_op_t       push_op
);

    localparam logic [INDEX_BITS:0] SLOTS_LIMIT = (INDEX_BITS + 1)'(SLOTS);

    logic                  busy_reg;
    logic                  busy_next;
    logic [INDEX_BITS-1:0] hidx;
    logic                  handle_ok;

    assign busy = busy_reg;
    assign push = start && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (push)
        begin
            busy_next = 1'b1;
        end
        else if (slot_taken)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign hidx      = req.handle_in[INDEX_BITS-1:0];
    assign handle_ok = (hidx != '0) && ({1'b0, hidx} < SLOTS_LIMIT);

    always_comb
    begin
        push_op         = '0;
        push_op.idx     = hidx[SLOT_BITS-1:0];
        push_op.gen     = req.handle_in[HANDLE_BITS-1:INDEX_BITS];
        push_op.payload = req.payload_in;
        push_op.stage   = (req.stage_in == STAGE_BAD) ? STAGE_VERTEX : req.stage_in;
        push_op.status  = ST_BAD;
        push_op.kind    = OP_REJECT;
        unique case (req.command)
            CMD_CREATE:
            begin
                if (req.payload_in == '0)
                begin
                    push_op.status = ST_ZERO;
                end
                else
                begin
                    push_op.kind = OP_CREATE;
                end
            end
            CMD_DESTROY:
            begin
                if (handle_ok)
                begin
                    push_op.kind = OP_DESTROY;
                end
            end
            CMD_LOOKUP:
            begin
                if (handle_ok)
                begin
                    push_op.kind = OP_LOOKUP;
                end
            end
            default:
            begin
                push_op.kind = OP_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ght_queue.sv =====
`default_nettype none

module ght_queue
    import ght_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire ght_op_t push_op,
    input  wire logic    pop,
    output logic         valid,
    output ght_op_t      head
);

    ght_op_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic                  do_pop;

    assign valid  = (count_reg != '0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !do_pop && (count_reg == Q_CNT_BITS'(Q_DEPTH))))
        else $error("queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !pop && !push) |=> (valid && $stable(rd_ptr_reg)))
        else $error("queue head lost without pop");

endmodule

`default_nettype wire

// ===== design/ght_back.sv =====
`default_nettype none

module ght_back
    import ght_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_valid,
    input  wire ght_op_t q_head,
    output logic         pop,
    output logic         slot_taken,
    output logic         done,
    output ght_rsp_t     rsp
);

    localparam logic [CNT_BITS-1:0] SLOTS_CNT = CNT_BITS'(SLOTS);
    localparam logic [GEN_BITS-1:0] GEN_MAX   = '1;

    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
    logic [STAGE_BITS-1:0]   stg_mem [SLOTS];
    logic [GEN_BITS-1:0]     gen_mem [SLOTS];
    logic [SLOT_BITS-1:0]    stk_mem [SLOTS];

    bk_state_t               state_reg, state_next;
    ght_op_t                 op_reg, op_next;
    logic [SLOT_BITS-1:0]    idx_reg, idx_next;
    logic                    fresh_reg, fresh_next;
    logic [CNT_BITS-1:0]     used_reg, used_next;
    logic [CNT_BITS-1:0]     free_reg, free_next;
    logic                    done_reg, done_next;
    ght_rsp_t                rsp_reg, rsp_next;

    logic [PAYLOAD_BITS-1:0] pay_rd_reg;
    logic [STAGE_BITS-1:0]   stg_rd_reg;
    logic [GEN_BITS-1:0]     gen_rd_reg;
    logic [SLOT_BITS-1:0]    stk_rd_reg;

    logic                    slot_re;
    logic [SLOT_BITS-1:0]    slot_raddr;
    logic                    stk_re;
    logic [SLOT_BITS-1:0]    stk_raddr;
    logic                    slot_we;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic                    meta_we;
    logic [GEN_BITS-1:0]     gen_wdata;
    logic                    stk_we;

    logic [GEN_BITS-1:0]     gen_cur;
    logic [GEN_BITS-1:0]     gen_new;
    logic                    handle_live;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign gen_cur     = fresh_reg ? '0 : gen_rd_reg;
    assign gen_new     = (gen_cur == GEN_MAX) ? GEN_BITS'(1) : gen_cur + 1'b1;
    assign handle_live = (CNT_BITS'(idx_reg) < used_reg) && (gen_rd_reg == op_reg.gen)
                         && (pay_rd_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        fresh_next = fresh_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        pop        = 1'b0;
        slot_taken = 1'b0;
        slot_re    = 1'b0;
        slot_raddr = idx_reg;
        stk_re     = 1'b0;
        stk_raddr  = SLOT_BITS'(free_reg - CNT_BITS'(1));
        slot_we    = 1'b0;
        pay_wdata  = op_reg.payload;
        meta_we    = 1'b0;
        gen_wdata  = gen_new;
        stk_we     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop     = 1'b1;
                    op_next = q_head;
                    if ((q_head.kind == OP_CREATE) && (free_reg != '0))
                    begin
                        stk_re     = 1'b1;
                        fresh_next = 1'b0;
                        state_next = BK_STACK;
                    end
                    else
                    begin
                        if (q_head.kind == OP_CREATE)
                        begin
                            idx_next   = SLOT_BITS'(used_reg);
                            fresh_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = q_head.idx;
                            fresh_next = 1'b0;
                        end
                        slot_re    = 1'b1;
                        slot_raddr = idx_next;
                        slot_taken = 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            BK_STACK:
            begin
                idx_next   = stk_rd_reg;
                slot_re    = 1'b1;
                slot_raddr = stk_rd_reg;
                slot_taken = 1'b1;
                state_next = BK_READ;
            end
            BK_READ:
            begin
                done_next  = 1'b1;
                rsp_next   = '0;
                state_next = BK_IDLE;
                unique case (op_reg.kind)
                    OP_CREATE:
                    begin
                        if (fresh_reg && (used_reg >= SLOTS_CNT))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            slot_we  = 1'b1;
                            meta_we  = 1'b1;
                            if (fresh_reg)
                            begin
                                used_next = used_reg + 1'b1;
                            end
                            else
                            begin
                                free_next = free_reg - 1'b1;
                            end
                            rsp_next.status     = ST_OK;
                            rsp_next.handle_out = {gen_new, INDEX_BITS'(idx_reg)};
                        end
                    end
                    OP_DESTROY:
                    begin
                        rsp_next.status = ST_BAD;
                        if (handle_live && (free_reg < SLOTS_CNT))
                        begin
                            slot_we         = 1'b1;
                            pay_wdata       = '0;
                            stk_we          = 1'b1;
                            free_next       = free_reg + 1'b1;
                            rsp_next.status = ST_OK;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        rsp_next.status = ST_BAD;
                        if (handle_live)
                        begin
                            rsp_next.status      = ST_OK;
                            rsp_next.payload_out = pay_rd_reg;
                            rsp_next.stage_out   = stg_rd_reg;
                        end
                    end
                    OP_REJECT:
                    begin
                        rsp_next.status = op_reg.status;
                    end
                    default:
                    begin
                        rsp_next.status = ST_BAD;
                    end
                endcase
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            used_reg  <= CNT_BITS'(1);
            free_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        fresh_reg <= fresh_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_re)
        begin
            pay_rd_reg <= pay_mem[slot_raddr];
            stg_rd_reg <= stg_mem[slot_raddr];
            gen_rd_reg <= gen_mem[slot_raddr];
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
        if (slot_we)
        begin
            pay_mem[idx_reg] <= pay_wdata;
        end
        if (meta_we)
        begin
            stg_mem[idx_reg] <= op_reg.stage;
            gen_mem[idx_reg] <= gen_wdata;
        end
        if (stk_we)
        begin
            stk_mem[SLOT_BITS'(free_reg)] <= idx_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BK_READ))
        else $error("result beat without slot pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_STACK) |=> (state_reg == BK_READ))
        else $error("stack pop not followed by slot pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg < used_reg) && (used_reg <= SLOTS_CNT))
        else $error("slot counters inconsistent");

endmodule

`default_nettype wire

// ===== design/generational_handle_slot_table.sv =====
// The result beat (done) is registered in BK_READ after the queue entry is
// popped and its slot read issued; a create that reuses a slot from the free
// stack first passes BK_STACK for the stack pop. A new command is accepted
// only after busy drops, once the slot read of the last one is issued.
// Reset clears the free count and sets the used-slot count to one; slots never
// handed out are tracked by the used-slot count, so no clearing pass is needed.
`default_nettype none

module generational_handle_slot_table
    import ght_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ght_req_t req,
    output logic          busy,
    output logic          done,
    output ght_rsp_t      rsp
);

    logic    push;
    ght_op_t push_op;
    logic    pop;
    logic    q_valid;
    ght_op_t q_head;
    logic    slot_taken;

    ght_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .busy       (busy),
        .slot_taken (slot_taken),
        .push       (push),
        .push_op    (push_op)
    );

    ght_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    ght_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .slot_taken (slot_taken),
        .done       (done),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
